FILE: rtl/angle_pair_histogram_distance_top_assert.svh
// ----------------------------------------------------------------------------
// Angle pair histogram distance: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ANGLE_PAIR_HISTOGRAM_DISTANCE_TOP_ASSERT_SVH
`define ANGLE_PAIR_HISTOGRAM_DISTANCE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define APHD_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define APHD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/aphd_pkg.sv
// ----------------------------------------------------------------------------
// aphd_pkg
// Shared widths, request codes and control structs of the angle pair histogram.
// ----------------------------------------------------------------------------
package aphd_pkg;

	localparam int REQ_W      = 2;
	localparam int ANGLE_W    = 20;
	localparam int IDX_IN_W   = 3;
	localparam int COUNT_W    = 16;
	localparam int ENTRY_W    = 24;
	localparam int ABS_W      = 22;
	localparam int SQ_W       = 38;
	localparam int SQ_TERM_W  = 2 * COUNT_W;
	// widest bin index on one axis (up to 64 bins)
	localparam int IDX_W      = 6;

	localparam int BINS_PER_AXIS_DEF   = 8;
	localparam int ANGLE_FRAC_BITS_DEF = 16;

	localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CMP   = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [ENTRY_W-1:0] ENTRY_MAX = '1;
	localparam logic [ABS_W-1:0]   ABS_MAX   = '1;
	localparam logic [SQ_W-1:0]    SQ_MAX    = '1;

	typedef struct packed {
		logic load;      // capture the input item
		logic rd;        // read the addressed bin
		logic calc;      // form new count and difference terms
		logic clr_step;  // zero one bin of the store
		logic commit;    // update totals, write back, present the result
	} aphd_cmd_t;

	typedef struct packed {
		logic is_clear;  // captured item is a clear request
		logic clr_last;  // sweep is at the final bin
		logic out_free;  // result register can take a new item
	} aphd_status_t;

endpackage

FILE: rtl/aphd_ctrl.sv
// ----------------------------------------------------------------------------
// aphd_ctrl
// Sequencer: reset sweep, item capture, read, compute and commit steps.
// ----------------------------------------------------------------------------
module aphd_ctrl
	import aphd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  aphd_status_t status,
	output aphd_cmd_t    cmd
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_CALC = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       init_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (status.clr_last)
					state_d = init_q ? ST_IDLE : ST_FIN;
			end
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_READ;
			end
			ST_READ: begin
				state_d = status.is_clear ? ST_CLR : ST_CALC;
			end
			ST_CALC: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			init_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			// drop the power-up flag once the first sweep ends
			if (state_q == ST_CLR && status.clr_last)
				init_q <= 1'b0;
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign cmd.load     = (state_q == ST_IDLE) && in_valid;
	assign cmd.rd       = (state_q == ST_READ);
	assign cmd.calc     = (state_q == ST_CALC);
	assign cmd.clr_step = (state_q == ST_CLR);
	assign cmd.commit   = (state_q == ST_FIN) && status.out_free;

endmodule

FILE: rtl/aphd_dp.sv
// ----------------------------------------------------------------------------
// aphd_dp
// Bin store, angle binning, saturating totals and distance accumulators.
// ----------------------------------------------------------------------------
module aphd_dp
	import aphd_pkg::*;
#(
	parameter int BINS_PER_AXIS   = BINS_PER_AXIS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  aphd_cmd_t           cmd,
	output aphd_status_t        status,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [ANGLE_W-1:0]  alpha_angle,
	input  logic [ANGLE_W-1:0]  beta_angle,
	input  logic [IDX_IN_W-1:0] bin_row,
	input  logic [IDX_IN_W-1:0] bin_col,
	input  logic [COUNT_W-1:0]  ref_count,
	input  logic                last_element,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ENTRY_W-1:0]  entry_total,
	output logic [COUNT_W-1:0]  peak_count,
	output logic [COUNT_W-1:0]  bin_value,
	output logic [ABS_W-1:0]    abs_distance,
	output logic [SQ_W-1:0]     sq_distance,
	output logic                distance_done
);

	localparam int N_BINS = BINS_PER_AXIS * BINS_PER_AXIS;
	localparam int AW     = $clog2(N_BINS);
	localparam int FW     = ANGLE_FRAC_BITS;
	localparam int PW     = FW + 7;
	localparam int XW     = 2 * IDX_W;
	localparam logic [AW-1:0] LAST_BIN = AW'(N_BINS - 1);

	// bin store
	logic [COUNT_W-1:0] store_mem [N_BINS];
	logic [COUNT_W-1:0] mem_rd_q;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [COUNT_W-1:0] mem_wd;
	logic [AW-1:0]      clr_cnt_q;

	// captured item
	logic [REQ_W-1:0]   req_q;
	logic [IDX_W-1:0]   row_q;
	logic [IDX_W-1:0]   col_q;
	logic               inrange_q;
	logic [COUNT_W-1:0] ref_q;
	logic               last_q;

	// compute stage
	logic [COUNT_W-1:0]   cnt_s1;
	logic [COUNT_W-1:0]   d_s1;
	logic [SQ_TERM_W-1:0] sq_s1;

	// architectural totals
	logic [ENTRY_W-1:0] entry_q;
	logic [COUNT_W-1:0] peak_q;
	logic [ABS_W-1:0]   abs_q;
	logic [SQ_W-1:0]    sq_q;
	logic               out_valid_q;

	logic [FW+ANGLE_W-1:0] alpha_ext, beta_ext;
	logic [PW-1:0]         alpha_prod, beta_prod;
	logic [IDX_W-1:0]      row_d, col_d;
	logic                  inrange_d;
	logic [XW-1:0]         flat_idx;
	logic [AW-1:0]         addr;
	logic [COUNT_W-1:0]    h;
	logic [COUNT_W-1:0]    d;
	logic [ABS_W:0]        abs_sum;
	logic [SQ_W:0]         sq_sum;
	logic [ABS_W-1:0]      abs_new;
	logic [SQ_W-1:0]       sq_new;
	logic [ENTRY_W-1:0]    entry_inc;

	// wrap modulo one turn, then scale to a sector index
	assign alpha_ext  = {{FW{1'b0}}, alpha_angle};
	assign beta_ext   = {{FW{1'b0}}, beta_angle};
	assign alpha_prod = PW'(alpha_ext[FW-1:0]) * PW'(BINS_PER_AXIS);
	assign beta_prod  = PW'(beta_ext[FW-1:0]) * PW'(BINS_PER_AXIS);

	always_comb begin
		if (req_type == REQ_CMP) begin
			row_d     = IDX_W'(bin_row);
			col_d     = IDX_W'(bin_col);
			inrange_d = (int'(bin_row) < BINS_PER_AXIS) && (int'(bin_col) < BINS_PER_AXIS);
		end else begin
			row_d     = alpha_prod[FW +: IDX_W];
			col_d     = beta_prod[FW +: IDX_W];
			inrange_d = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= req_type;
			row_q     <= row_d;
			col_q     <= col_d;
			inrange_q <= inrange_d;
			ref_q     <= ref_count;
			last_q    <= last_element;
		end
	end

	assign flat_idx = XW'(row_q) * XW'(BINS_PER_AXIS) + XW'(col_q);
	assign addr     = flat_idx[AW-1:0];

	assign mem_we = cmd.clr_step || (cmd.commit && req_q == REQ_ADD);
	assign mem_wa = cmd.clr_step ? clr_cnt_q : addr;
	assign mem_wd = cmd.clr_step ? '0 : cnt_s1;

	always_ff @(posedge clk) begin
		if (mem_we)
			store_mem[mem_wa] <= mem_wd;
		if (cmd.rd)
			mem_rd_q <= store_mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= (clr_cnt_q == LAST_BIN) ? '0 : clr_cnt_q + AW'(1);
		end
	end

	// out-of-range compare bins read as empty
	assign h = inrange_q ? mem_rd_q : '0;
	assign d = (h >= ref_q) ? h - ref_q : ref_q - h;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			case (req_q)
				REQ_ADD: cnt_s1 <= (h == COUNT_MAX) ? h : h + COUNT_W'(1);
				REQ_CMP: cnt_s1 <= h;
				default: cnt_s1 <= '0;
			endcase
			d_s1  <= d;
			sq_s1 <= SQ_TERM_W'(d) * SQ_TERM_W'(d);
		end
	end

	assign abs_sum   = {1'b0, abs_q} + (ABS_W+1)'(d_s1);
	assign sq_sum    = {1'b0, sq_q} + (SQ_W+1)'(sq_s1);
	assign abs_new   = abs_sum[ABS_W] ? ABS_MAX : abs_sum[ABS_W-1:0];
	assign sq_new    = sq_sum[SQ_W] ? SQ_MAX : sq_sum[SQ_W-1:0];
	assign entry_inc = (entry_q == ENTRY_MAX) ? entry_q : entry_q + ENTRY_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			peak_q  <= '0;
			abs_q   <= '0;
			sq_q    <= '0;
		end else if (cmd.commit) begin
			case (req_q)
				REQ_ADD: begin
					entry_q <= entry_inc;
					if (cnt_s1 > peak_q)
						peak_q <= cnt_s1;
				end
				REQ_CLEAR: begin
					entry_q <= '0;
					peak_q  <= '0;
				end
				REQ_CMP: begin
					abs_q <= last_q ? '0 : abs_new;
					sq_q  <= last_q ? '0 : sq_new;
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			case (req_q)
				REQ_ADD: begin
					entry_total <= entry_inc;
					peak_count  <= (cnt_s1 > peak_q) ? cnt_s1 : peak_q;
				end
				REQ_CLEAR: begin
					entry_total <= '0;
					peak_count  <= '0;
				end
				default: begin
					entry_total <= entry_q;
					peak_count  <= peak_q;
				end
			endcase
			// a clear skips the compute step, so its bin count is forced empty
			bin_value     <= (req_q == REQ_CLEAR) ? '0 : cnt_s1;
			abs_distance  <= (req_q == REQ_CMP) ? abs_new : abs_q;
			sq_distance   <= (req_q == REQ_CMP) ? sq_new : sq_q;
			distance_done <= (req_q == REQ_CMP) && last_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.is_clear = (req_q == REQ_CLEAR);
	assign status.clr_last = (clr_cnt_q == LAST_BIN);
	assign status.out_free = !out_valid_q || out_ready;

endmodule

FILE: rtl/angle_pair_histogram_distance_top.sv
// ----------------------------------------------------------------------------
// angle_pair_histogram_distance_top
// 2D angle pair histogram with saturating totals and distance to a reference.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   -------------------   ---------------------------------------------
//  input     in_valid / in_ready   req_type, alpha_angle, beta_angle, bin_row,
//                                  bin_col, ref_count, last_element
//  result    out_valid / out_ready entry_total, peak_count, bin_value,
//                                  abs_distance, sq_distance, distance_done
//
//  An add, compare or unused item runs through capture, bin store read,
//  compute and commit before the next item is accepted; the bin store read is
//  registered and the write-back of an add follows it at commit.
//  A clear item runs through capture, read, a sweep of the store one bin a
//  cycle, then commit. After reset the same sweep runs with in_ready low.
//  A result waits in its output register; a stalled result holds the commit
//  step, and the next item is accepted as soon as the sequencer is idle.
//
module angle_pair_histogram_distance_top
	import aphd_pkg::*;
#(
	parameter int BINS_PER_AXIS   = BINS_PER_AXIS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// input items
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [ANGLE_W-1:0]  alpha_angle,
	input  logic [ANGLE_W-1:0]  beta_angle,
	input  logic [IDX_IN_W-1:0] bin_row,
	input  logic [IDX_IN_W-1:0] bin_col,
	input  logic [COUNT_W-1:0]  ref_count,
	input  logic                last_element,
	// result items
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ENTRY_W-1:0]  entry_total,
	output logic [COUNT_W-1:0]  peak_count,
	output logic [COUNT_W-1:0]  bin_value,
	output logic [ABS_W-1:0]    abs_distance,
	output logic [SQ_W-1:0]     sq_distance,
	output logic                distance_done
);

	aphd_cmd_t    cmd;
	aphd_status_t status;

	// sequencer: owns the step order and the handshake on the input side
	aphd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: bin store, arithmetic and the result register
	aphd_dp #(
		.BINS_PER_AXIS   (BINS_PER_AXIS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.req_type      (req_type),
		.alpha_angle   (alpha_angle),
		.beta_angle    (beta_angle),
		.bin_row       (bin_row),
		.bin_col       (bin_col),
		.ref_count     (ref_count),
		.last_element  (last_element),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.entry_total   (entry_total),
		.peak_count    (peak_count),
		.bin_value     (bin_value),
		.abs_distance  (abs_distance),
		.sq_distance   (sq_distance),
		.distance_done (distance_done)
	);

	`include "angle_pair_histogram_distance_top_assert.svh"

	// never take an item while the store is being swept or a result committed
	`APHD_ASSERT_NOW(a_idle_no_work, in_ready, !cmd.clr_step && !cmd.commit, "busy while ready")
	// a commit must find the result register free
	`APHD_ASSERT_NOW(a_commit_free, cmd.commit, status.out_free, "result overwritten")
	// every commit presents a result in the next cycle
	`APHD_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid, "result not presented")

endmodule
